// ===== hdl/narac_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and modular helpers for the arrangement counter.
// No dependencies; every other file imports this package.
package narac_pkg;

    // Field widths fixed by the item format
    localparam int COUNT_W = 4;
    localparam int RES_W   = 30;

    // Default largest letter count handled by the table
    localparam int MAX_COUNT_DEF = 15;

    // Prime modulus of the count
    localparam logic [RES_W-1:0] ARR_MOD = 30'd1000000007;

    typedef logic [RES_W-1:0] t_res;

    // One table cell: a residue for each possible last letter
    typedef logic [2:0][RES_W-1:0] t_cell;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the counts of a new item
        logic issue;  // read neighbors of the current cell and advance
        logic sum1;   // add the first two residues of the final cell
        logic sum2;   // add the third residue and load the result register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic last;   // the cell being issued is the final one
    } t_sts;

    // Sum of two residues, reduced once (both inputs below the modulus)
    function automatic t_res add_mod(input t_res a, input t_res b);
        logic [RES_W:0] s;
        logic [RES_W:0] d;
        s = {1'b0, a} + {1'b0, b};
        d = s - {1'b0, ARR_MOD};
        add_mod = (s >= {1'b0, ARR_MOD}) ? d[RES_W-1:0] : s[RES_W-1:0];
    endfunction

endpackage

// ===== hdl/narac_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input and result items.
// Depends on narac_pkg for the field widths.
interface narac_in_if
    import narac_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] count_a;
    logic [COUNT_W-1:0] count_b;
    logic [COUNT_W-1:0] count_c;

    modport source (output valid, output count_a, output count_b, output count_c,
                    input ready);
    modport sink   (input valid, input count_a, input count_b, input count_c,
                    output ready);
endinterface

interface narac_out_if
    import narac_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [RES_W-1:0] arrangement_count;

    modport source (output valid, output arrangement_count, input ready);
    modport sink   (input valid, input arrangement_count, output ready);
endinterface

// ===== hdl/narac_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the table sweep: accepts items, runs the sweep, the final
// reduction and the result handshake. Depends on narac_pkg.
module narac_ctrl
    import narac_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_SUM1  = 3'd3;
    localparam logic [2:0] S_SUM2  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_vld, n_out_vld;
    logic       out_free;

    assign out_free    = !r_out_vld || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

    // Next state and commands
    always_comb begin
        n_state   = r_state;
        n_out_vld = r_out_vld && !i_out_ready;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SWEEP;
                end
            end
            S_SWEEP: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_SUM1;
            end
            S_SUM1: begin
                o_cmd.sum1 = 1'b1;
                n_state    = S_SUM2;
            end
            S_SUM2: begin
                // hold until the result register can take the new item
                if (out_free) begin
                    o_cmd.sum2 = 1'b1;
                    n_out_vld  = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

// ===== hdl/narac_dp.sv =====
`timescale 1ns / 1ps
// Datapath: cell counters, residue table memory, one-cell-per-cycle update
// pipeline with forwarding, final reduction and result register. Depends on narac_pkg.
module narac_dp
    import narac_pkg::*;
#(
    parameter int MAX_COUNT = MAX_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic [COUNT_W-1:0] i_count_a,
    input  logic [COUNT_W-1:0] i_count_b,
    input  logic [COUNT_W-1:0] i_count_c,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output t_res               o_result
);

    localparam int CW    = $clog2(MAX_COUNT + 1);
    localparam int AW    = 3 * CW;
    localparam int DEPTH = 1 << AW;

    // Saturate an input count at the largest table index
    function automatic logic [CW-1:0] clamp_count(input logic [COUNT_W-1:0] v);
        clamp_count = (32'(v) > MAX_COUNT) ? CW'(MAX_COUNT) : CW'(v);
    endfunction

    t_cell mem [DEPTH];

    logic [CW-1:0] r_na, r_nb, r_nc;
    logic [CW-1:0] r_i, r_j, r_k;
    logic [CW-1:0] r_bi, r_bj, r_bk;
    logic          r_b_vld;
    logic          r_fwd_i, r_fwd_j;
    t_cell         r_rd_i, r_rd_j;
    t_cell         r_prev;
    t_res          r_acc;
    t_res          r_result;

    logic          k_end, j_end;
    t_cell         nb_i, nb_j;
    t_cell         cell_val;

    assign k_end      = (r_k == r_nc);
    assign j_end      = (r_j == r_nb);
    assign o_sts.last = (r_i == r_na) && j_end && k_end;
    assign o_result   = r_result;

    // Capture counts and advance the sweep position, k fastest
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_na <= clamp_count(i_count_a);
            r_nb <= clamp_count(i_count_b);
            r_nc <= clamp_count(i_count_c);
            r_i  <= '0;
            r_j  <= '0;
            r_k  <= '0;
        end else if (i_cmd.issue) begin
            if (!k_end) begin
                r_k <= r_k + 1'b1;
            end else begin
                r_k <= '0;
                if (!j_end) begin
                    r_j <= r_j + 1'b1;
                end else begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

    // Read the neighbor cells one step back along i and j; wrap at zero is masked later
    always_ff @(posedge i_clk) begin
        r_rd_i <= mem[{r_i - 1'b1, r_j, r_k}];
        r_rd_j <= mem[{r_i, r_j - 1'b1, r_k}];
    end

    // Carry the cell position to the update stage; flag neighbors that are
    // the cell just computed, whose write has not landed yet
    always_ff @(posedge i_clk) begin
        r_b_vld <= i_cmd.issue;
        r_bi    <= r_i;
        r_bj    <= r_j;
        r_bk    <= r_k;
        r_fwd_j <= (r_nc == '0);
        r_fwd_i <= (r_nb == '0) && (r_nc == '0);
    end

    assign nb_i = r_fwd_i ? r_prev : r_rd_i;
    assign nb_j = r_fwd_j ? r_prev : r_rd_j;

    // Residue for each last letter from the other two residues one step back
    always_comb begin
        if (r_bi == CW'(1) && r_bj == '0 && r_bk == '0) begin
            cell_val[0] = t_res'(1);
        end else if (r_bi != '0) begin
            cell_val[0] = add_mod(nb_i[1], nb_i[2]);
        end else begin
            cell_val[0] = '0;
        end
        if (r_bi == '0 && r_bj == CW'(1) && r_bk == '0) begin
            cell_val[1] = t_res'(1);
        end else if (r_bj != '0) begin
            cell_val[1] = add_mod(nb_j[0], nb_j[2]);
        end else begin
            cell_val[1] = '0;
        end
        if (r_bi == '0 && r_bj == '0 && r_bk == CW'(1)) begin
            cell_val[2] = t_res'(1);
        end else if (r_bk != '0) begin
            cell_val[2] = add_mod(r_prev[0], r_prev[1]);
        end else begin
            cell_val[2] = '0;
        end
    end

    // Write the finished cell and keep it as the k-1 neighbor of the next one
    always_ff @(posedge i_clk) begin
        if (r_b_vld) begin
            mem[{r_bi, r_bj, r_bk}] <= cell_val;
            r_prev                  <= cell_val;
        end
    end

    // Reduce the final cell into the result register: sum1 adds the first two residues, sum2 adds the third
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum1) begin
            r_acc <= add_mod(r_prev[0], r_prev[1]);
        end
        if (i_cmd.sum2) begin
            r_result <= add_mod(r_acc, r_prev[2]);
        end
    end

endmodule

// ===== hdl/no_adjacent_repeat_arrangement_count.sv =====
`timescale 1ns / 1ps
// Counts three-letter arrangements with no two equal letters adjacent, mod 1e9+7.
// The sweep fills one table cell per cycle through the single-write residue memory,
// then the final cell is reduced into the result register.
// A new item is accepted only once the previous result is in the result register.
// Reset clears the sequencer and the result valid; the table is not cleared.
// Depends on narac_pkg, narac_if, narac_ctrl and narac_dp.
module no_adjacent_repeat_arrangement_count
    import narac_pkg::*;
#(
    parameter int MAX_COUNT = MAX_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    narac_in_if.sink      i_in,
    narac_out_if.source   o_out
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    narac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Table sweep datapath
    narac_dp #(
        .MAX_COUNT (MAX_COUNT)
    ) u_dp (
        .i_clk     (i_clk),
        .i_count_a (i_in.count_a),
        .i_count_b (i_in.count_b),
        .i_count_c (i_in.count_c),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_result  (o_out.arrangement_count)
    );

endmodule
